/* rtl/boot_script_font_selection_scanner_macros.svh */
// assertion macros shared by the scanner rtl
// no dependencies; expects clk and rst in the including module
`ifndef BOOT_SCRIPT_FONT_SELECTION_SCANNER_MACROS_SVH
`define BOOT_SCRIPT_FONT_SELECTION_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFS_ASSERT_NEVER(lbl, cond, msg) \
  `BFS_ASSERT(lbl, !(cond), msg)
`else
`define BFS_ASSERT(lbl, prop, msg)
`define BFS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/bfs_pkg.sv */
// types, character constants and helper functions for the font scanner
// no dependencies
package bfs_pkg;

  localparam logic [15:0] SYSTEM_FONT = 16'hFFFF;
  localparam logic [7:0]  CH_NL    = 8'h0A;
  localparam logic [7:0]  CH_SP    = 8'h20;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_STAR  = 8'h2A;
  localparam logic [7:0]  CH_COMMA = 8'h2C;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_AMP   = 8'h26;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_X     = 8'h78;
  localparam logic [7:0]  CH_H     = 8'h68;
  localparam logic [7:0]  CH_SEMI  = 8'h3B;
  localparam logic [7:0]  CH_USCORE = 8'h5F;
  localparam logic [6:0]  NO_DIGIT = 7'd99;
  localparam logic [6:0]  MAX_RADIX = 7'd36;
  localparam logic [13:0] PREFIX_SAT = 14'd1000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIM_L, ST_TRIM_R, ST_WORD, ST_SKIP, ST_AMP, ST_X, ST_PRE,
    ST_RUN, ST_DIG, ST_SUF, ST_SEMI, ST_END, ST_DONE, ST_EMIT
  } st_t;

  typedef struct packed {
    logic too_long;
    logic last;
  } job_flags_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  // base-36 digit value, NO_DIGIT for anything else
  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] l;
    l = to_low(c);
    if (is_dec(c)) return 7'(c - 8'h30);
    if (l >= 8'h61 && l <= 8'h7A) return 7'(l - 8'h61) + 7'd10;
    return NO_DIGIT;
  endfunction

  function automatic logic [7:0] font_char(input logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      3'd0: r = 8'h66;
      3'd1: r = 8'h6F;
      3'd2: r = 8'h6E;
      3'd3: r = 8'h74;
      3'd4: r = 8'h63;
      3'd5: r = 8'h74;
      3'd6: r = 8'h6C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] vdu_char(input logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      3'd0: r = 8'h76;
      3'd1: r = 8'h64;
      3'd2: r = 8'h75;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // leading arguments that a vdu line must carry: 23 0 149 0
  function automatic logic [15:0] vdu_want(input logic [2:0] k);
    logic [15:0] r;
    r = 16'd0;
    unique case (k)
      3'd0: r = 16'd23;
      3'd2: r = 16'h0095;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/bfs_channels.sv */
// valid/ready channel interfaces for script input and font result
// no dependencies
interface bfs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] text_byte;
  modport source (output valid, cmd, text_byte, input ready);
  modport sink (input valid, cmd, text_byte, output ready);
endinterface

interface bfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] font_id;
  modport source (output valid, font_id, input ready);
  modport sink (input valid, font_id, output ready);
endinterface

/* rtl/bfs_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/bfs_jobq.sv */
// two-entry queue of finished-line jobs between front and back
// no dependencies
module bfs_jobq #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         q_valid,
  output logic [W-1:0] q_data
);
  logic [W-1:0] slot [2];
  logic         rd_ptr;
  logic         wr_ptr;
  logic [1:0]   count;

  assign q_valid = (count != 2'd0);
  assign q_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/bfs_front.sv */
// front end: takes script bytes, stores the current line, queues line jobs
// depends on bfs_pkg and bfs_channels
module bfs_front #(
  parameter int LINE_MAX = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  bfs_in_if.sink                          in_ch,
  input  logic                            allow,
  output logic                            we,
  output logic [$clog2(LINE_MAX)-1:0]     waddr,
  output logic [7:0]                      wdata,
  output logic                            push,
  output logic [$clog2(LINE_MAX+1)-1:0]   push_len,
  output bfs_pkg::job_flags_t             push_flags
);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int AW = $clog2(LINE_MAX);

  logic [LW-1:0] length;
  logic          too_long;
  logic          take;
  logic          is_term;

  assign in_ch.ready = allow;
  assign take    = in_ch.valid && allow;
  assign is_term = in_ch.cmd || (in_ch.text_byte == bfs_pkg::CH_NL);

  assign we    = take && !is_term && !too_long && (length < LW'(LINE_MAX));
  assign waddr = length[AW-1:0];
  assign wdata = in_ch.text_byte;

  assign push                = take && is_term;
  assign push_len            = length;
  assign push_flags.too_long = too_long;
  assign push_flags.last     = in_ch.cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      too_long <= 1'b0;
    end else if (take) begin
      if (is_term) begin
        length   <= '0;
        too_long <= 1'b0;
      end else if (!too_long) begin
        if (length < LW'(LINE_MAX)) length <= length + LW'(1);
        else too_long <= 1'b1;
      end
    end
  end
endmodule

/* rtl/bfs_back.sv */
// back end: trims a stored line, matches the command and parses numbers
// depends on bfs_pkg, bfs_channels and the macros header
`include "boot_script_font_selection_scanner_macros.svh"
module bfs_back #(
  parameter int LINE_MAX = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [$clog2(LINE_MAX+1)-1:0]   q_len,
  input  bfs_pkg::job_flags_t             q_flags,
  output logic                            q_pop,
  output logic                            idle,
  output logic [$clog2(LINE_MAX)-1:0]     raddr,
  input  logic [7:0]                      rdata,
  bfs_out_if.source                       out_ch
);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int PW = LW + 1;
  localparam int AW = $clog2(LINE_MAX);

  bfs_pkg::st_t st, st_next;
  logic [PW-1:0] ptr, ptr_next, sb, sb_next, se, se_next, mark, mark_next;
  logic [2:0]    kw, kw_next, kn, kn_next;
  logic          fok, fok_next, vok, vok_next;
  logic          mode_vdu, mode_vdu_next, last, last_next;
  logic          neg, neg_next, dg, dg_next, pd, pd_next;
  logic [5:0]    base, base_next;
  logic [15:0]   val, val_next, sel, sel_next, font_id, font_id_next;
  logic [13:0]   pb, pb_next;
  logic [7:0]    lastc, lastc_next;
  logic          out_valid, out_valid_next;

  logic [7:0]  c;
  logic        inr;
  logic [6:0]  dv;
  logic [21:0] prod;
  logic [15:0] nv;
  logic        num_done, num_ok, start_num;

  assign c    = rdata;
  assign inr  = ptr < se;
  assign dv   = bfs_pkg::digit_of(c);
  assign prod = 22'(val) * 22'(base) + 22'(dv);
  assign nv   = neg ? (16'h0000 - val) : val;
  assign raddr = ptr_next[AW-1:0];
  assign idle  = (st == bfs_pkg::ST_IDLE);

  assign out_ch.valid   = out_valid;
  assign out_ch.font_id = font_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= bfs_pkg::ST_IDLE;
      sel       <= bfs_pkg::SYSTEM_FONT;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
    ptr <= ptr_next;  sb <= sb_next;  se <= se_next;  mark <= mark_next;
    kw <= kw_next;  kn <= kn_next;  fok <= fok_next;  vok <= vok_next;
    mode_vdu <= mode_vdu_next;  last <= last_next;  neg <= neg_next;
    dg <= dg_next;  pd <= pd_next;  base <= base_next;  val <= val_next;
    pb <= pb_next;  lastc <= lastc_next;  font_id <= font_id_next;
  end

  always_comb begin
    st_next = st;  ptr_next = ptr;  sb_next = sb;  se_next = se;
    mark_next = mark;  kw_next = kw;  kn_next = kn;  fok_next = fok;
    vok_next = vok;  mode_vdu_next = mode_vdu;  last_next = last;
    neg_next = neg;  dg_next = dg;  pd_next = pd;  base_next = base;
    val_next = val;  pb_next = pb;  lastc_next = lastc;  sel_next = sel;
    font_id_next = font_id;
    out_valid_next = out_valid && !out_ch.ready;
    q_pop = 1'b0;
    num_done = 1'b0;
    num_ok = 1'b0;
    start_num = 1'b0;

    unique case (st)
      bfs_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          last_next = q_flags.last;
          se_next   = PW'(q_len);
          ptr_next  = '0;
          if (q_flags.too_long || q_len == '0) st_next = bfs_pkg::ST_DONE;
          else st_next = bfs_pkg::ST_TRIM_L;
        end
      end
      bfs_pkg::ST_TRIM_L: begin
        if (inr && (bfs_pkg::is_blank(c) || c == bfs_pkg::CH_STAR)) begin
          ptr_next = ptr + PW'(1);
        end else begin
          sb_next  = ptr;
          ptr_next = se - PW'(1);
          st_next  = inr ? bfs_pkg::ST_TRIM_R : bfs_pkg::ST_DONE;
        end
      end
      bfs_pkg::ST_TRIM_R: begin
        if (se > sb && bfs_pkg::is_blank(c)) begin
          se_next  = se - PW'(1);
          ptr_next = se - PW'(2);
        end else begin
          ptr_next = sb;
          kw_next  = 3'd0;
          fok_next = 1'b1;
          vok_next = 1'b1;
          st_next  = bfs_pkg::ST_WORD;
        end
      end
      bfs_pkg::ST_WORD: begin
        // both command words are matched in one pass
        if (kw == 3'd7) begin
          if (fok && (!inr || bfs_pkg::is_blank(c))) begin
            mode_vdu_next = 1'b0;
            ptr_next      = sb + PW'(7);
            start_num     = 1'b1;
          end else if (vok) begin
            mode_vdu_next = 1'b1;
            kn_next       = 3'd0;
            ptr_next      = sb + PW'(3);
            start_num     = 1'b1;
          end else begin
            st_next = bfs_pkg::ST_DONE;
          end
        end else begin
          fok_next = fok && inr && (bfs_pkg::to_low(c) == bfs_pkg::font_char(kw));
          if (kw < 3'd3) begin
            vok_next = vok && inr && (bfs_pkg::to_low(c) == bfs_pkg::vdu_char(kw));
          end else if (kw == 3'd3) begin
            vok_next = vok && (!inr || bfs_pkg::is_blank(c));
          end
          kw_next  = kw + 3'd1;
          ptr_next = ptr + PW'(1);
        end
      end
      bfs_pkg::ST_SKIP: begin
        if (inr && (bfs_pkg::is_blank(c) || c == bfs_pkg::CH_COMMA)) begin
          ptr_next = ptr + PW'(1);
        end else if (!inr) begin
          num_done = 1'b1;
        end else if (c == bfs_pkg::CH_MINUS || c == bfs_pkg::CH_PLUS) begin
          neg_next = (c == bfs_pkg::CH_MINUS);
          ptr_next = ptr + PW'(1);
          st_next  = bfs_pkg::ST_AMP;
        end else begin
          st_next = bfs_pkg::ST_AMP;
        end
      end
      bfs_pkg::ST_AMP: begin
        mark_next = ptr;
        if (inr && c == bfs_pkg::CH_AMP) begin
          base_next = 6'd16;
          ptr_next  = ptr + PW'(1);
          st_next   = bfs_pkg::ST_DIG;
        end else if ((ptr + PW'(1)) < se && c == bfs_pkg::CH_ZERO) begin
          ptr_next = ptr + PW'(1);
          st_next  = bfs_pkg::ST_X;
        end else begin
          pb_next = '0;
          pd_next = 1'b0;
          st_next = bfs_pkg::ST_PRE;
        end
      end
      bfs_pkg::ST_X: begin
        if (bfs_pkg::to_low(c) == bfs_pkg::CH_X) begin
          base_next = 6'd16;
          ptr_next  = ptr + PW'(1);
          st_next   = bfs_pkg::ST_DIG;
        end else begin
          ptr_next = mark;
          pb_next  = '0;
          pd_next  = 1'b0;
          st_next  = bfs_pkg::ST_PRE;
        end
      end
      bfs_pkg::ST_PRE: begin
        // decimal run that may turn out to be a base prefix
        if (inr && bfs_pkg::is_dec(c)) begin
          if (pb < bfs_pkg::PREFIX_SAT) begin
            pb_next = 14'(pb * 14'd10) + 14'(c - bfs_pkg::CH_ZERO);
          end
          pd_next  = 1'b1;
          ptr_next = ptr + PW'(1);
        end else if (pd && inr && c == bfs_pkg::CH_USCORE) begin
          if (pb < 14'd2 || pb > 14'(bfs_pkg::MAX_RADIX)) begin
            num_done = 1'b1;
          end else begin
            base_next = 6'(pb);
            ptr_next  = ptr + PW'(1);
            st_next   = bfs_pkg::ST_DIG;
          end
        end else begin
          ptr_next = mark;
          pd_next  = 1'b0;
          st_next  = bfs_pkg::ST_RUN;
        end
      end
      bfs_pkg::ST_RUN: begin
        // look ahead over the alphanumeric run for an h suffix
        if (inr && dv < bfs_pkg::MAX_RADIX) begin
          lastc_next = c;
          pd_next    = 1'b1;
          ptr_next   = ptr + PW'(1);
        end else begin
          base_next = (pd && bfs_pkg::to_low(lastc) == bfs_pkg::CH_H) ? 6'd16 : 6'd10;
          ptr_next  = mark;
          st_next   = bfs_pkg::ST_DIG;
        end
      end
      bfs_pkg::ST_DIG: begin
        if (inr && dv < 7'(base)) begin
          if (prod > 22'(bfs_pkg::SYSTEM_FONT)) begin
            num_done = 1'b1;
          end else begin
            val_next = prod[15:0];
            dg_next  = 1'b1;
            ptr_next = ptr + PW'(1);
          end
        end else if (!dg) begin
          num_done = 1'b1;
        end else begin
          st_next = bfs_pkg::ST_SUF;
        end
      end
      bfs_pkg::ST_SUF: begin
        if (base == 6'd16 && inr && bfs_pkg::to_low(c) == bfs_pkg::CH_H) begin
          ptr_next = ptr + PW'(1);
        end
        st_next = bfs_pkg::ST_SEMI;
      end
      bfs_pkg::ST_SEMI: begin
        if (inr && c == bfs_pkg::CH_SEMI) ptr_next = ptr + PW'(1);
        st_next = bfs_pkg::ST_END;
      end
      bfs_pkg::ST_END: begin
        num_done = 1'b1;
        num_ok   = !(inr && !bfs_pkg::is_blank(c) && c != bfs_pkg::CH_COMMA);
      end
      bfs_pkg::ST_DONE: begin
        st_next = last ? bfs_pkg::ST_EMIT : bfs_pkg::ST_IDLE;
      end
      bfs_pkg::ST_EMIT: begin
        if (!out_valid || out_ch.ready) begin
          out_valid_next = 1'b1;
          font_id_next   = sel;
          sel_next       = bfs_pkg::SYSTEM_FONT;
          st_next        = bfs_pkg::ST_IDLE;
        end
      end
      default: st_next = bfs_pkg::ST_IDLE;
    endcase

    // outcome of one number
    if (num_done) begin
      st_next = bfs_pkg::ST_DONE;
      if (!mode_vdu) begin
        sel_next = num_ok ? nv : bfs_pkg::SYSTEM_FONT;
      end else if (kn < 3'd4) begin
        if (num_ok && nv == bfs_pkg::vdu_want(kn)) begin
          kn_next   = kn + 3'd1;
          start_num = 1'b1;
        end
      end else if (num_ok) begin
        sel_next = nv;
      end
    end

    if (start_num) begin
      neg_next  = 1'b0;
      val_next  = '0;
      dg_next   = 1'b0;
      base_next = '0;
      st_next   = bfs_pkg::ST_SKIP;
    end
  end

  `BFS_ASSERT(a_word_span, (st == bfs_pkg::ST_WORD) |-> (sb < se), "empty word span")
  `BFS_ASSERT(a_base_range, (st == bfs_pkg::ST_DIG) |-> (base >= 6'd2 && base <= 6'd36), "radix")
  `BFS_ASSERT(a_emit_origin, $rose(out_valid) |-> $past(st == bfs_pkg::ST_EMIT), "stray result")
  `BFS_ASSERT_NEVER(a_pop_busy, q_pop && (st != bfs_pkg::ST_IDLE), "job taken while busy")
endmodule

/* rtl/boot_script_font_selection_scanner.sv */
// script bytes: one per cycle while the back end is idle and no line job waits; a newline or
// end of text queues the line and holds input off while the back end scans it, one store
// read per cycle; after end of text the result is registered once the last line is scanned
// and the back end has gone through its done and emit states
// synchronous active-high reset empties the job queue and sets the selection to 65535
module boot_script_font_selection_scanner #(
  parameter int LINE_MAX = 128
) (
  input  logic       clk,
  input  logic       rst,
  bfs_in_if.sink     in_ch,
  bfs_out_if.source  out_ch
);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int AW = $clog2(LINE_MAX);

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [7:0]          wdata, rdata;
  logic                push, pop, q_valid, back_idle;
  logic [LW-1:0]       push_len;
  bfs_pkg::job_flags_t push_flags;
  logic [LW+1:0]       q_data;

  // the line store is shared, so bytes wait until the back end is done with it
  bfs_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk, .rst, .in_ch, .allow(back_idle && !q_valid),
    .we, .waddr, .wdata, .push, .push_len, .push_flags
  );

  bfs_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  bfs_jobq #(.W(LW + 2)) u_jobq (
    .clk, .rst, .push, .push_data({push_len, push_flags}), .pop,
    .q_valid, .q_data
  );

  bfs_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk, .rst, .q_valid, .q_len(q_data[LW+1:2]), .q_flags(q_data[1:0]),
    .q_pop(pop), .idle(back_idle), .raddr, .rdata, .out_ch
  );
endmodule
